// ----- rtl/fixed_entry_allocator_defines.svh -----
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
`ifndef FIXED_ENTRY_ALLOCATOR_DEFINES_SVH
`define FIXED_ENTRY_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FEA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fea: same-cycle check failed");

// next-cycle implication
`define FEA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fea: next-cycle check failed");

`endif

// ----- rtl/fea_pkg.sv -----
package fea_pkg;

    localparam int unsigned ADDR_W         = 12;
    localparam int unsigned STRIDE_W       = 12;
    localparam int unsigned LINK_DEPTH     = 4096;
    localparam int unsigned MAX_PLACES_DEF = 4096;
    localparam int unsigned PDATA_W        = 32;
    localparam int unsigned PADDR_W        = 3;
    localparam int unsigned REG_IDX_W      = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_STRIDE = REG_IDX_W'(0);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_CLEAR   = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [ADDR_W-1:0]   place_in;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]   place_out;
        logic                status;
        logic                created;
    } t_out_item;

    // register block -> core
    typedef struct packed {
        logic [STRIDE_W-1:0] stride;
        logic                clear;
        logic [STRIDE_W-1:0] clear_stride;
    } t_cfg_ctl;

    // core -> link memory
    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   wdata;
    } t_link_req;

endpackage

// ----- rtl/fea_link_mem.sv -----
module fea_link_mem
    import fea_pkg::*;
(
    input  logic              i_clk,
    input  t_link_req         i_req,
    output logic [ADDR_W-1:0] o_rdata
);

    logic [ADDR_W-1:0] r_mem [LINK_DEPTH];
    logic [ADDR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/fea_cfg.sv -----
module fea_cfg
    import fea_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg_ctl           o_cfg
);

    logic [STRIDE_W-1:0] r_stride;
    logic [STRIDE_W-1:0] n_stride;
    logic                hit;
    logic                wr_stride;

    assign hit       = (paddr[PADDR_W-1:2] == REG_STRIDE);
    assign wr_stride = psel && penable && pwrite && hit;

    // a zero stride is taken as one
    assign n_stride = (pwdata[STRIDE_W-1:0] == '0) ? STRIDE_W'(1) : pwdata[STRIDE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_W'(1);
        end else if (wr_stride) begin
            r_stride <= n_stride;
        end
    end

    assign prdata = hit ? PDATA_W'(r_stride) : '0;
    assign pready = 1'b1;

    assign o_cfg.stride       = r_stride;
    assign o_cfg.clear        = wr_stride;
    assign o_cfg.clear_stride = n_stride;

endmodule

// ----- rtl/fea_core.sv -----
module fea_core
    import fea_pkg::*;
#(
    parameter int unsigned MAX_PLACES = MAX_PLACES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg_ctl          i_cfg,
    input  logic              i_in_valid,
    input  t_in_item          i_in_data,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output t_out_item         o_out_data,
    input  logic              i_out_ready,
    output t_link_req         o_link_req,
    input  logic [ADDR_W-1:0] i_link_rdata
);

    localparam int unsigned CAP_W  = $clog2(MAX_PLACES + 1);
    localparam int unsigned BUMP_W = (CAP_W > STRIDE_W + 1) ? CAP_W : STRIDE_W + 1;
    localparam int unsigned SUM_W  = BUMP_W + 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state            r_state;
    t_opcode           r_op;
    logic [ADDR_W-1:0] r_place;
    logic [BUMP_W-1:0] r_bump;
    logic [BUMP_W-1:0] n_bump;
    logic [ADDR_W-1:0] r_free_head;
    logic [ADDR_W-1:0] n_free_head;
    logic              r_out_valid;
    t_out_item         r_out_data;
    t_out_item         n_out_data;
    logic              in_fire;
    logic              done;
    logic [SUM_W-1:0]  bump_sum;

    assign in_fire = i_in_valid && (r_state == S_IDLE);
    assign done    = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // head link is fetched at accept and used in S_EXEC
    assign o_link_req.rd_en = in_fire;
    assign o_link_req.wr_en = done && (r_op == OP_RELEASE) && (r_place != '0);
    assign o_link_req.addr  = in_fire ? r_free_head : r_place;
    assign o_link_req.wdata = r_free_head;

    assign bump_sum = SUM_W'(r_bump) + SUM_W'(i_cfg.stride);

    always_comb begin
        n_bump      = r_bump;
        n_free_head = r_free_head;
        n_out_data  = '0;
        unique case (r_op)
            OP_ALLOC: begin
                if (r_free_head != '0) begin
                    n_out_data.place_out = r_free_head;
                    n_free_head          = i_link_rdata;
                end else if (bump_sum > SUM_W'(MAX_PLACES)) begin
                    n_out_data.status = 1'b1;
                end else begin
                    n_out_data.place_out = r_bump[ADDR_W-1:0];
                    n_bump               = bump_sum[BUMP_W-1:0];
                end
            end
            OP_RELEASE: begin
                if (r_place != '0) begin
                    n_free_head = r_place;
                end
            end
            OP_QUERY: begin
                n_out_data.created = (r_place >= i_cfg.stride)
                                  && (BUMP_W'(r_place) < r_bump);
            end
            OP_CLEAR: begin
                n_bump      = BUMP_W'(i_cfg.stride);
                n_free_head = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_ALLOC;
            r_place     <= '0;
            r_out_valid <= 1'b0;
            r_bump      <= BUMP_W'(1);
            r_free_head <= '0;
        end else begin
            if (r_out_valid && i_out_ready && !done) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op    <= i_in_data.opcode;
                        r_place <= i_in_data.place_in;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (done) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= n_out_data;
                        if (!i_cfg.clear) begin
                            r_bump      <= n_bump;
                            r_free_head <= n_free_head;
                        end
                        r_state     <= S_IDLE;
                    end
                end
            endcase
            // stride write restarts the allocator
            if (i_cfg.clear) begin
                r_bump      <= BUMP_W'(i_cfg.clear_stride);
                r_free_head <= '0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/fixed_entry_allocator.sv -----
// Channel   Valid/ready               Beat
// in        i_in_valid / o_in_ready   i_in_data  (opcode, place_in)
// out       o_out_valid / i_out_ready o_out_data (place_out, status, created)
// cfg       psel, penable, pwrite     paddr, pwdata -> prdata (stride at 0x0)
//
// Per item, the accept cycle launches the link memory read of the free-list head;
// S_EXEC then uses the read data and loads the output beat once the out slot is free.
// A new item is taken while the previous beat still waits on i_out_ready.
// Synchronous active-low reset; the link memory is not cleared and needs no pass.
`include "fixed_entry_allocator_defines.svh"

module fixed_entry_allocator
    import fea_pkg::*;
#(
    parameter int unsigned MAX_PLACES = MAX_PLACES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data
);

    t_cfg_ctl          cfg;
    t_link_req         link_req;
    logic [ADDR_W-1:0] link_rdata;

    fea_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fea_core #(
        .MAX_PLACES (MAX_PLACES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_ready  (i_out_ready),
        .o_link_req   (link_req),
        .i_link_rdata (link_rdata)
    );

    fea_link_mem u_link_mem (
        .i_clk   (i_clk),
        .i_req   (link_req),
        .o_rdata (link_rdata)
    );

    `FEA_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready)
    `FEA_ASSERT_NOW(a_full_no_place, o_out_valid && o_out_data.status, o_out_data.place_out == '0)
    `FEA_ASSERT_NOW(a_query_clean, o_out_valid && o_out_data.created, (o_out_data.place_out == '0) && !o_out_data.status)
    `FEA_ASSERT_NOW(a_link_port, link_req.rd_en, !link_req.wr_en)

endmodule
